[hdl/software_timer_manager_defines.svh]
// assertion macros for the timer manager checker
`ifndef SOFTWARE_TIMER_MANAGER_DEFINES_SVH
`define SOFTWARE_TIMER_MANAGER_DEFINES_SVH

`define STM_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define STM_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

[hdl/stm_pkg.sv]
`default_nettype none
package stm_pkg;

  localparam int DL_W  = 49;
  localparam int NOW_W = 48;
  localparam int SEQ_W = 32;
  localparam int DLY_W = 32;
  localparam int NT_W  = 31;
  localparam int CMD_W = 3;
  localparam int ST_W  = 3;
  localparam int TH_W  = 16;
  localparam logic [NT_W-1:0] NT_MAX = {NT_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_ONESHOT = 3'd1,
    CMD_PERIOD  = 3'd2,
    CMD_RESCHED = 3'd3,
    CMD_CANCEL  = 3'd4,
    CMD_STOP    = 3'd5,
    CMD_NOP6    = 3'd6,
    CMD_NOP7    = 3'd7
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_EXPIRED  = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_STOPPED  = 3'd4
  } status_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [NOW_W-1:0] now;
    logic [DLY_W-1:0] delay;
    logic [SEQ_W-1:0] tseq;
    logic [TH_W-1:0]  task_h;
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_EMIT, S_UPDATE, S_NEXT, S_FINAL
  } state_t;

endpackage
`default_nettype wire

[hdl/stm_front.sv]
`default_nettype none
module stm_front
  import stm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [CMD_W-1:0]   in_cmd,
  input  wire logic [NOW_W-1:0]   in_now_ms,
  input  wire logic [DLY_W-1:0]   in_delay_ms,
  input  wire logic [SEQ_W-1:0]   in_timer_seq,
  input  wire logic [TH_W-1:0]    in_task_handle,
  output logic                    q_valid,
  output req_t                    q_req,
  input  wire logic               q_pop
);

  // two-entry request queue
  req_t        mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push;
  req_t        req;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = mem_r[rp_r];

  always_comb begin
    req.cmd    = cmd_t'(in_cmd);
    req.now    = in_now_ms;
    req.delay  = in_delay_ms;
    req.tseq   = in_timer_seq;
    req.task_h = in_task_handle;
    // periodic timers never use a zero period
    if (req.cmd == CMD_PERIOD && in_delay_ms == '0) begin
      req.delay = DLY_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

[hdl/stm_back.sv]
`default_nettype none
module stm_back
  import stm_pkg::*;
#(
  parameter int CAPACITY  = 16,
  parameter int TASK_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [NT_W-1:0]   cfg_wr_data,
  input  wire logic              q_valid,
  input  wire req_t              q_req,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ST_W-1:0]        out_status,
  output logic [TH_W-1:0]        out_task_handle_out,
  output logic [SEQ_W-1:0]       out_seq_out,
  output logic [DL_W-1:0]        out_deadline_out,
  output logic [NT_W-1:0]        out_next_timeout,
  output logic                   out_last
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [DL_W-1:0]      dl_r   [CAPACITY];
  logic [SEQ_W-1:0]     seq_r  [CAPACITY];
  logic [TASK_BITS-1:0] task_r [CAPACITY];
  logic [DLY_W-1:0]     per_r  [CAPACITY];
  logic [CAPACITY-1:0]  valid_r, periodic_r;

  logic [SEQ_W-1:0] seq_cnt_r;
  logic             running_r;
  logic [NT_W-1:0]  idle_r;

  state_t state_r, state_nxt;
  req_t   cur_r;
  logic [CW-1:0] idx_r;

  // scan results
  logic          found_r;
  logic [IW-1:0] best_r;
  logic          free_found_r;
  logic [IW-1:0] free_r;
  logic          any_r;
  logic [DL_W-1:0] min_r;

  logic [IW-1:0] ix;
  logic          scan_done;
  logic          e_due, e_better, e_match, e_min;

  logic [DL_W-1:0] now_ext;

  assign ix        = idx_r[IW-1:0];
  assign scan_done = (idx_r == CW'(CAPACITY - 1));
  assign now_ext   = {1'b0, cur_r.now};

  always_comb begin
    e_due    = valid_r[ix] && (dl_r[ix] <= now_ext);
    e_better = !found_r || (dl_r[ix] < dl_r[best_r]) ||
               ((dl_r[ix] == dl_r[best_r]) && (seq_r[ix] < seq_r[best_r]));
    e_match  = valid_r[ix] && (seq_r[ix] == cur_r.tseq);
    e_min    = valid_r[ix] && (!any_r || dl_r[ix] < min_r);
  end

  // output register
  logic           ov_r;
  logic [ST_W-1:0]  o_st_r;
  logic [TH_W-1:0]  o_th_r;
  logic [SEQ_W-1:0] o_sq_r;
  logic [DL_W-1:0]  o_dl_r;
  logic [NT_W-1:0]  o_nt_r;
  logic             o_last_r;
  logic             out_free;
  logic             ov_load;

  assign out_free            = !ov_r || out_ready;
  assign ov_load             = out_free && (state_r == S_EMIT || state_r == S_FINAL);
  assign out_valid           = ov_r;
  assign out_status          = o_st_r;
  assign out_task_handle_out = o_th_r;
  assign out_seq_out         = o_sq_r;
  assign out_deadline_out    = o_dl_r;
  assign out_next_timeout    = o_nt_r;
  assign out_last            = o_last_r;

  // final-item fields held during processing
  logic [ST_W-1:0]  f_st_r;
  logic [SEQ_W-1:0] f_sq_r;
  logic [DL_W-1:0]  f_dl_r;

  logic [NT_W-1:0] nt_val;
  logic [DL_W-1:0] diff;

  always_comb begin
    diff = min_r - now_ext;
    if (!any_r) begin
      nt_val = idle_r;
    end else if (min_r <= now_ext) begin
      nt_val = '0;
    end else if (diff > DL_W'(NT_MAX)) begin
      nt_val = NT_MAX;
    end else begin
      nt_val = diff[NT_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (q_valid) state_nxt = S_SCAN;
      S_SCAN:   if (scan_done) state_nxt = S_UPDATE;
      S_UPDATE: begin
        if (cur_r.cmd == CMD_TICK && running_r && found_r) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_EMIT:   if (out_free) state_nxt = S_SCAN;
      S_NEXT:   if (scan_done) state_nxt = S_FINAL;
      S_FINAL:  if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state_r == S_IDLE) && q_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r <= NT_MAX;
    end else if (cfg_wr_en) begin
      idle_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      valid_r    <= '0;
      periodic_r <= '0;
      seq_cnt_r  <= '0;
      running_r  <= 1'b1;
      ov_r       <= 1'b0;
      idx_r      <= '0;
      found_r    <= 1'b0;
      free_found_r <= 1'b0;
      any_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ov_load) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cur_r        <= q_req;
            idx_r        <= '0;
            found_r      <= 1'b0;
            free_found_r <= 1'b0;
          end
        end
        S_SCAN: begin
          if (cur_r.cmd == CMD_TICK) begin
            if (e_due && e_better) begin
              found_r <= 1'b1;
              best_r  <= ix;
            end
          end else if (e_match && !found_r) begin
            found_r <= 1'b1;
            best_r  <= ix;
          end
          if (!valid_r[ix] && !free_found_r) begin
            free_found_r <= 1'b1;
            free_r       <= ix;
          end
          idx_r <= scan_done ? '0 : idx_r + CW'(1);
        end
        S_EMIT: begin
          if (out_free) begin
            o_st_r   <= ST_EXPIRED;
            o_th_r   <= TH_W'(task_r[best_r]);
            o_sq_r   <= seq_r[best_r];
            o_dl_r   <= dl_r[best_r];
            o_nt_r   <= '0;
            o_last_r <= 1'b0;
            if (periodic_r[best_r]) begin
              dl_r[best_r] <= now_ext + DL_W'(per_r[best_r]);
            end else begin
              valid_r[best_r] <= 1'b0;
            end
            found_r <= 1'b0;
            idx_r   <= '0;
          end
        end
        S_UPDATE: begin
          any_r  <= 1'b0;
          idx_r  <= '0;
          f_st_r <= ST_OK;
          f_sq_r <= '0;
          f_dl_r <= '0;
          unique case (cur_r.cmd)
            CMD_TICK: begin
              if (!running_r) f_st_r <= ST_STOPPED;
            end
            CMD_ONESHOT, CMD_PERIOD: begin
              if (!running_r) begin
                f_st_r <= ST_STOPPED;
              end else if (!free_found_r) begin
                f_st_r <= ST_FULL;
              end else begin
                seq_cnt_r <= seq_cnt_r + SEQ_W'(1);
                f_sq_r    <= seq_cnt_r;
                f_dl_r    <= now_ext + DL_W'(cur_r.delay);
                valid_r[free_r]    <= 1'b1;
                periodic_r[free_r] <= (cur_r.cmd == CMD_PERIOD);
                dl_r[free_r]       <= now_ext + DL_W'(cur_r.delay);
                seq_r[free_r]      <= seq_cnt_r;
                task_r[free_r]     <= cur_r.task_h[TASK_BITS-1:0];
                per_r[free_r]      <= cur_r.delay;
              end
            end
            CMD_RESCHED: begin
              if (!running_r) begin
                f_st_r <= ST_STOPPED;
              end else begin
                seq_cnt_r <= seq_cnt_r + SEQ_W'(1);
                if (!found_r) begin
                  f_st_r <= ST_NOTFOUND;
                end else begin
                  f_sq_r <= seq_cnt_r;
                  f_dl_r <= now_ext + DL_W'(cur_r.delay);
                  dl_r[best_r]       <= now_ext + DL_W'(cur_r.delay);
                  seq_r[best_r]      <= seq_cnt_r;
                  periodic_r[best_r] <= 1'b0;
                end
              end
            end
            CMD_CANCEL: begin
              if (!found_r) begin
                f_st_r <= ST_NOTFOUND;
              end else begin
                f_sq_r <= seq_r[best_r];
                f_dl_r <= dl_r[best_r];
                valid_r[best_r]    <= 1'b0;
                periodic_r[best_r] <= 1'b0;
              end
            end
            CMD_STOP: begin
              running_r  <= 1'b0;
              valid_r    <= '0;
              periodic_r <= '0;
            end
            default: ;
          endcase
        end
        S_NEXT: begin
          if (e_min) begin
            any_r <= 1'b1;
            min_r <= dl_r[ix];
          end
          idx_r <= scan_done ? '0 : idx_r + CW'(1);
        end
        S_FINAL: begin
          if (out_free) begin
            o_st_r   <= f_st_r;
            o_th_r   <= '0;
            o_sq_r   <= f_sq_r;
            o_dl_r   <= f_dl_r;
            o_nt_r   <= nt_val;
            o_last_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/software_timer_manager.sv]
`default_nettype none
// Timer manager holding CAPACITY timers. Each request is served by one-entry-a-cycle scans
// of the timer table: one to find the named timer or a free slot, one more after each
// expired timer, and one to find the next deadline; a two-entry queue in front accepts
// requests meanwhile. Every request yields a final result with last high; a tick first
// returns each due timer in (deadline, sequence) order.
module software_timer_manager
  import stm_pkg::*;
#(
  parameter int CAPACITY  = 16,
  parameter int TASK_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [NT_W-1:0]   cfg_wr_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CMD_W-1:0]  in_cmd,
  input  wire logic [NOW_W-1:0]  in_now_ms,
  input  wire logic [DLY_W-1:0]  in_delay_ms,
  input  wire logic [SEQ_W-1:0]  in_timer_seq,
  input  wire logic [TH_W-1:0]   in_task_handle,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ST_W-1:0]        out_status,
  output logic [TH_W-1:0]        out_task_handle_out,
  output logic [SEQ_W-1:0]       out_seq_out,
  output logic [DL_W-1:0]        out_deadline_out,
  output logic [NT_W-1:0]        out_next_timeout,
  output logic                   out_last
);

  logic q_valid, q_pop;
  req_t q_req;

  stm_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_now_ms, .in_delay_ms,
    .in_timer_seq, .in_task_handle, .q_valid, .q_req, .q_pop
  );

  stm_back #(.CAPACITY(CAPACITY), .TASK_BITS(TASK_BITS)) u_back (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data, .q_valid, .q_req, .q_pop,
    .out_valid, .out_ready, .out_status, .out_task_handle_out, .out_seq_out,
    .out_deadline_out, .out_next_timeout, .out_last
  );

endmodule
`default_nettype wire

[hdl/stm_checker.sv]
`default_nettype none
`include "software_timer_manager_defines.svh"
module stm_checker
  import stm_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [ST_W-1:0]  out_status,
  input wire logic [NT_W-1:0]  out_next_timeout,
  input wire logic             out_last
);

  `STM_ASSERT_IMPL(a_exp_not_last, clk, rst_n, out_valid && out_status == ST_EXPIRED |-> !out_last, "expired item marked last")
  `STM_ASSERT_IMPL(a_exp_nt_zero, clk, rst_n, out_valid && !out_last |-> out_next_timeout == '0, "nonzero timeout on expired item")
  `STM_ASSERT_IMPL(a_nonlast_exp, clk, rst_n, out_valid && !out_last |-> out_status == ST_EXPIRED, "non-final item not expired")
  `STM_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_last), "result dropped while stalled")

endmodule

bind software_timer_manager stm_checker u_chk (
  .clk, .rst_n, .out_valid, .out_ready, .out_status, .out_next_timeout, .out_last
);
`default_nettype wire
